[rtl/core/dtf_pkg.sv]
package dtf_pkg;

  // history and coefficient layout
  localparam int unsigned Order    = 4;
  localparam int unsigned Depth    = 4;
  localparam int unsigned NumTerms = 2 * Depth;

  // number formats: samples Q16.16, coefficients Q8.24
  localparam int unsigned DataW    = 32;
  localparam int unsigned CoefW    = 32;
  localparam int unsigned FracBits = 24;
  localparam int unsigned ProdW    = DataW + CoefW;
  localparam int unsigned AccW     = ProdW + $clog2(NumTerms);
  localparam int unsigned RoundW   = AccW - FracBits;

  // register map
  localparam int unsigned CfgIdxW = $clog2(NumTerms);
  localparam logic [CfgIdxW-1:0] CfgFbBase = '0;
  localparam logic [CfgIdxW-1:0] CfgFfBase = CfgIdxW'(Depth);

  // beat operation codes
  typedef enum logic {
    MODE_STEP = 1'b0,
    MODE_INIT = 1'b1
  } filt_mode_e;

  typedef logic signed [DataW-1:0] sample_t;
  typedef logic signed [CoefW-1:0] coef_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [AccW-1:0]  acc_t;

  localparam acc_t    HalfLsb   = acc_t'(1) <<< (FracBits - 1);
  localparam sample_t SampleMax = {1'b0, {(DataW - 1){1'b1}}};
  localparam sample_t SampleMin = {1'b1, {(DataW - 1){1'b0}}};

endpackage

[rtl/core/discrete_transfer_function_filter_top.sv]
// Order-4 direct-form transfer function filter, Q16.16 samples and Q8.24
// coefficients. A step beat (mode 0) returns one result: the sum of the
// feed-forward coefficients times the stored inputs minus the feedback
// coefficients times the stored outputs, rounded half up to Q16.16 and
// saturated (saturated_o flags a clip). The current sample only enters the
// history, so the output lags the input by one sample. An init beat (mode 1)
// fills both histories with its rest levels and returns nothing. Both
// histories are cleared by reset, as are the eight coefficient registers
// (index 0..3 feedback, 4..7 feed-forward, oldest tap first). One beat is
// taken every clock cycle while the result side keeps up; a step result is
// in the output register on the edge after its beat is accepted, as long as
// that register can take it. The cycle time is set by the feedback loop:
// eight 32x32 multiplies, their sum, rounding and saturation run
// combinationally from the history registers back into them.
module discrete_transfer_function_filter_top
  import dtf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // input channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               mode_i,
  input  logic [DataW-1:0]   sample_i,
  input  logic [DataW-1:0]   rest_output_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [DataW-1:0]   filter_output_o,
  output logic               saturated_o,
  // configuration write port
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CoefW-1:0]   cfg_wdata_i
);

  // coefficient registers
  coef_t fb_coef_q [Depth];
  coef_t ff_coef_q [Depth];

  // filter state, oldest entry first
  sample_t in_hist_q  [Depth];
  sample_t in_hist_d  [Depth];
  sample_t out_hist_q [Depth];
  sample_t out_hist_d [Depth];

  // input register
  logic       in_valid_q;
  filt_mode_e mode_q;
  sample_t    sample_q;
  sample_t    rest_q;

  // result register
  logic    out_valid_q;
  logic    out_valid_d;
  sample_t out_data_q;
  logic    out_sat_q;

  // datapath
  prod_t                ff_prod [Depth];
  prod_t                fb_prod [Depth];
  acc_t                 acc;
  acc_t                 acc_rnd;
  logic [RoundW-1:0]    rnd;
  logic [RoundW-DataW:0] rnd_top;
  logic                 ovf;
  sample_t              y;

  logic fire;
  logic step_fire;

  // the item in the input register moves on when its result has a place;
  // an init beat needs no result slot
  assign fire       = in_valid_q && ((mode_q == MODE_INIT) || !out_valid_q || out_ready_i);
  assign step_fire  = fire && (mode_q == MODE_STEP);
  assign in_ready_o = !in_valid_q || fire;

  // coefficient writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) begin
        fb_coef_q[i] <= '0;
        ff_coef_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      for (int i = 0; i < Depth; i++) begin
        if (cfg_idx_i == CfgIdxW'(CfgFbBase + i)) fb_coef_q[i] <= coef_t'(cfg_wdata_i);
        if (cfg_idx_i == CfgIdxW'(CfgFfBase + i)) ff_coef_q[i] <= coef_t'(cfg_wdata_i);
      end
    end
  end

  // input register: payload needs no reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      mode_q   <= filt_mode_e'(mode_i);
      sample_q <= sample_t'(sample_i);
      rest_q   <= sample_t'(rest_output_i);
    end
  end

  // one product per tap, all taps in parallel
  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      ff_prod[i] = ff_coef_q[i] * in_hist_q[i];
      fb_prod[i] = fb_coef_q[i] * out_hist_q[i];
    end
  end

  // exact sum of the active taps
  always_comb begin
    acc = '0;
    for (int i = 0; i < Order; i++) begin
      acc = acc + acc_t'(ff_prod[i]) - acc_t'(fb_prod[i]);
    end
  end

  // round half up to Q16.16, then clip to 32 bits
  assign acc_rnd = acc + HalfLsb;
  assign rnd     = acc_rnd[AccW-1:FracBits];
  assign rnd_top = rnd[RoundW-1:DataW-1];
  assign ovf     = !((&rnd_top) || (~|rnd_top));

  always_comb begin
    if (ovf) begin
      y = rnd[RoundW-1] ? SampleMin : SampleMax;
    end else begin
      y = sample_t'(rnd[DataW-1:0]);
    end
  end

  // history update: init fills, step shifts toward the oldest end
  always_comb begin
    in_hist_d  = in_hist_q;
    out_hist_d = out_hist_q;
    if (fire) begin
      if (mode_q == MODE_INIT) begin
        for (int i = 0; i < Depth; i++) begin
          in_hist_d[i]  = sample_q;
          out_hist_d[i] = rest_q;
        end
      end else begin
        for (int i = 0; i < Order - 1; i++) begin
          in_hist_d[i]  = in_hist_q[i+1];
          out_hist_d[i] = out_hist_q[i+1];
        end
        in_hist_d[Order-1]  = sample_q;
        out_hist_d[Order-1] = y;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) begin
        in_hist_q[i]  <= '0;
        out_hist_q[i] <= '0;
      end
    end else begin
      in_hist_q  <= in_hist_d;
      out_hist_q <= out_hist_d;
    end
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (step_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      out_data_q <= y;
      out_sat_q  <= ovf;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign filter_output_o = out_data_q;
  assign saturated_o     = out_sat_q;

  // a result only ever comes from a step beat
  a_rise_from_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(step_fire))
    else $error("result raised without a step beat");

  // a clipped result sits on one of the rails
  a_sat_on_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_sat_q) |-> (out_data_q == SampleMax || out_data_q == SampleMin))
    else $error("saturated result not at a rail");

  // the fed-back output is the one delivered
  a_feedback_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_fire |=> (out_hist_q[Order-1] == out_data_q && out_valid_q))
    else $error("newest output history differs from result");

  // init fills both histories with the rest levels
  a_init_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && mode_q == MODE_INIT) |=> (in_hist_q[0] == $past(sample_q) &&
                                       out_hist_q[Depth-1] == $past(rest_q)))
    else $error("init beat did not fill histories");

endmodule

[bench/tb_discrete_transfer_function_filter_top.sv]
`timescale 1ns / 1ps

module tb_discrete_transfer_function_filter_top
  import dtf_pkg::*;
();

  localparam int ClkHalf     = 5;
  localparam int ResetCycles = 3;
  // settle time after the last result before touching the registers or ending
  localparam int TailCycles  = 6;
  localparam int RandPhases  = 7;
  localparam int PhaseItems  = 150;

  localparam coef_t CoefMax       = 32'sh7FFFFFFF;
  localparam coef_t CoefMin       = 32'sh80000000;
  localparam coef_t CoefOne       = 32'sh01000000;
  localparam coef_t CoefHalf      = 32'sh00800000;
  localparam coef_t CoefMinusHalf = 32'shFF800000;

  typedef struct packed {
    sample_t value;
    logic    sat;
  } filt_result_t;

  // one row of the directed table; a row with load set reprograms the
  // coefficients first, and a row with fixed set carries its own expectation
  typedef struct packed {
    logic       load;
    logic [1:0] set_id;
    filt_mode_e mode;
    sample_t    sample;
    sample_t    rest;
    logic       fixed;
    sample_t    want_value;
    logic       want_sat;
  } stim_row_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               in_valid_i    = 1'b0;
  logic               in_ready_o;
  logic               mode_i        = 1'b0;
  logic [DataW-1:0]   sample_i      = '0;
  logic [DataW-1:0]   rest_output_i = '0;
  logic               out_valid_o;
  logic               out_ready_i   = 1'b0;
  logic [DataW-1:0]   filter_output_o;
  logic               saturated_o;
  logic               cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i     = '0;
  logic [CoefW-1:0]   cfg_wdata_i   = '0;

  discrete_transfer_function_filter_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .mode_i          (mode_i),
    .sample_i        (sample_i),
    .rest_output_i   (rest_output_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .filter_output_o (filter_output_o),
    .saturated_o     (saturated_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  always #ClkHalf clk_i = ~clk_i;

  // shadow of the filter: coefficients and both histories, oldest first
  coef_t   fb_coef   [Depth];
  coef_t   ff_coef   [Depth];
  sample_t out_hist  [Depth];
  sample_t in_hist   [Depth];
  // coefficient set staged for the next register load
  coef_t   fb_next   [Depth];
  coef_t   ff_next   [Depth];
  // directed coefficient sets
  coef_t   fb_sets   [4][Depth];
  coef_t   ff_sets   [4][Depth];

  filt_result_t pending_outputs[$];
  stim_row_t    stim_rows[$];
  int           fail_count = 0;

  // receiver stall pattern
  int stall_style = 0;
  int stall_left  = 0;
  int stall_tick  = 0;

  // one filter step on the shadow state: exact sum of products, round half
  // up to Q16.16, clip, then shift both histories
  function automatic void filter_step(input sample_t x, output sample_t y, output logic sat);
    logic signed [71:0] acc;
    logic signed [71:0] rnd;
    longint             p_ff;
    longint             p_fb;
    int                 k;
    acc = '0;
    for (k = 0; k < Order; k++) begin
      p_ff = longint'(ff_coef[k]) * longint'(in_hist[k]);
      p_fb = longint'(fb_coef[k]) * longint'(out_hist[k]);
      acc  = acc + p_ff - p_fb;
    end
    rnd = (acc + 72'sd8388608) >>> FracBits;
    if (rnd > SampleMax) begin
      y   = SampleMax;
      sat = 1'b1;
    end else if (rnd < SampleMin) begin
      y   = SampleMin;
      sat = 1'b1;
    end else begin
      y   = rnd[DataW-1:0];
      sat = 1'b0;
    end
    for (k = 0; k + 1 < Order; k++) begin
      out_hist[k] = out_hist[k+1];
      in_hist[k]  = in_hist[k+1];
    end
    out_hist[Order-1] = y;
    in_hist[Order-1]  = x;
  endfunction

  function automatic sample_t rand_sample();
    sample_t v;
    case ($urandom_range(0, 5))
      0: v = $urandom();
      1: v = $urandom_range(0, 1 << 20);
      2: v = SampleMax;
      3: v = SampleMin;
      4: v = $urandom_range(0, 2);
      default: v = $urandom_range(0, 1 << 24);
    endcase
    if ($urandom_range(0, 1) != 0 && v != SampleMin && v != SampleMax) v = -v;
    return v;
  endfunction

  // style 0 keeps the loop gentle, higher styles let anything through
  function automatic coef_t rand_coef(input int style);
    coef_t c;
    case (style == 0 ? $urandom_range(0, 1) : $urandom_range(0, 5))
      0: c = 0;
      1: c = $urandom_range(0, 1 << 22);
      2: c = $urandom();
      3: c = CoefMax;
      4: c = CoefMin;
      default: c = $urandom_range(0, 1 << 25);
    endcase
    if ($urandom_range(0, 1) != 0 && c != CoefMin && c != CoefMax) c = -c;
    return c;
  endfunction

  // drop valid and let every pending result come home, plus a settle margin
  // since an init beat may still be in flight with nothing expected
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  task automatic idle_cycles(input int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // write all eight coefficients from the staged set, block idle
  task automatic load_coefs();
    int k;
    wait_drained();
    for (k = 0; k < 2 * Depth; k++) begin
      cfg_we_i <= 1'b1;
      if (k < Depth) begin
        cfg_idx_i   <= CfgFbBase + CfgIdxW'(k);
        cfg_wdata_i <= fb_next[k];
      end else begin
        cfg_idx_i   <= CfgFfBase + CfgIdxW'(k - Depth);
        cfg_wdata_i <= ff_next[k-Depth];
      end
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    for (k = 0; k < Depth; k++) begin
      fb_coef[k] = fb_next[k];
      ff_coef[k] = ff_next[k];
    end
    @(posedge clk_i);
  endtask

  // offer one beat, hold it until taken, then update the shadow
  task automatic send_beat(input filt_mode_e m, input sample_t s, input sample_t r,
                           input logic fixed, input sample_t wv, input logic ws);
    sample_t y;
    logic    sat;
    int      k;
    in_valid_i    <= 1'b1;
    mode_i        <= m;
    sample_i      <= s;
    rest_output_i <= r;
    do @(posedge clk_i); while (!in_ready_o);
    if (m == MODE_INIT) begin
      for (k = 0; k < Depth; k++) begin
        out_hist[k] = r;
        in_hist[k]  = s;
      end
    end else begin
      filter_step(s, y, sat);
      if (fixed) pending_outputs.push_back('{value: wv, sat: ws});
      else pending_outputs.push_back('{value: y, sat: sat});
    end
  endtask

  // result side: check each beat against the oldest expectation, and vary
  // ready between always-on, coin-flip and one-in-four stretches
  always @(posedge clk_i) begin
    filt_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_outputs.size() == 0) begin
        $display("%0t: result beat with nothing pending, got %h sat %b",
                 $time, filter_output_o, saturated_o);
        fail_count++;
      end else begin
        want = pending_outputs.pop_front();
        if (filter_output_o !== want.value) begin
          $display("%0t: filter_output mismatch, expected %h, got %h",
                   $time, want.value, filter_output_o);
          fail_count++;
        end
        if (saturated_o !== want.sat) begin
          $display("%0t: saturated mismatch, expected %b, got %b",
                   $time, want.sat, saturated_o);
          fail_count++;
        end
      end
    end
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 2);
      stall_left  = $urandom_range(5, 60);
    end
    stall_left--;
    stall_tick++;
    case (stall_style)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= ($urandom_range(0, 1) != 0);
      default: out_ready_i <= (stall_tick % 4 == 0);
    endcase
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    stim_row_t row;
    int        k;
    int        ph;
    int        n;
    int        style;
    int        burst_left;
    filt_mode_e m;

    for (k = 0; k < Depth; k++) begin
      fb_coef[k]    = 0;
      ff_coef[k]    = 0;
      out_hist[k]   = 0;
      in_hist[k]    = 0;
      // extremes that drive the sum far past either rail
      fb_sets[0][k] = CoefMin;
      ff_sets[0][k] = CoefMax;
      // half gain on the newest input only, for the rounding tie
      fb_sets[1][k] = 0;
      ff_sets[1][k] = (k == Depth - 1) ? CoefHalf : coef_t'(0);
      // unit delay with half feedback of the newest output
      fb_sets[2][k] = (k == Depth - 1) ? CoefMinusHalf : coef_t'(0);
      ff_sets[2][k] = (k == Depth - 1) ? CoefOne : coef_t'(0);
      // opposite extremes, which cancel exactly on mirrored rest levels
      fb_sets[3][k] = CoefMax;
      ff_sets[3][k] = CoefMin;
    end

    // directed table: load, set, mode, sample, rest, fixed, value, sat
    // zero coefficients after reset give zero whatever goes in
    stim_rows.push_back('{1'b0, 2'd0, MODE_STEP, SampleMax, SampleMin, 1'b1, 32'sd0, 1'b0});
    stim_rows.push_back('{1'b0, 2'd0, MODE_STEP, SampleMin, SampleMax, 1'b1, 32'sd0, 1'b0});
    stim_rows.push_back('{1'b0, 2'd0, MODE_INIT, SampleMax, SampleMin, 1'b0, 32'sd0, 1'b0});
    stim_rows.push_back('{1'b0, 2'd0, MODE_STEP, 32'sh12345678, 32'sd0, 1'b1, 32'sd0, 1'b0});
    // clip high then clip low
    stim_rows.push_back('{1'b1, 2'd0, MODE_INIT, SampleMax, SampleMax, 1'b0, 32'sd0, 1'b0});
    stim_rows.push_back('{1'b0, 2'd0, MODE_STEP, 32'sd0, 32'sd0, 1'b1, SampleMax, 1'b1});
    stim_rows.push_back('{1'b0, 2'd0, MODE_INIT, SampleMin, SampleMin, 1'b0, 32'sd0, 1'b0});
    stim_rows.push_back('{1'b0, 2'd0, MODE_STEP, SampleMax, 32'sd0, 1'b1, SampleMin, 1'b1});
    stim_rows.push_back('{1'b0, 2'd0, MODE_STEP, 32'sd0, 32'sd0, 1'b0, 32'sd0, 1'b0});
    // half an lsb either side of zero
    stim_rows.push_back('{1'b1, 2'd1, MODE_INIT, 32'sd1, 32'sd0, 1'b0, 32'sd0, 1'b0});
    stim_rows.push_back('{1'b0, 2'd1, MODE_STEP, 32'sd0, 32'sd0, 1'b0, 32'sd0, 1'b0});
    stim_rows.push_back('{1'b0, 2'd1, MODE_INIT, -32'sd1, 32'sd0, 1'b0, 32'sd0, 1'b0});
    stim_rows.push_back('{1'b0, 2'd1, MODE_STEP, 32'sd3, 32'sd0, 1'b0, 32'sd0, 1'b0});
    stim_rows.push_back('{1'b0, 2'd1, MODE_STEP, -32'sd3, 32'sd0, 1'b0, 32'sd0, 1'b0});
    stim_rows.push_back('{1'b0, 2'd1, MODE_STEP, 32'sd0, 32'sd0, 1'b0, 32'sd0, 1'b0});
    // one-sample delay with feedback
    stim_rows.push_back('{1'b1, 2'd2, MODE_STEP, 32'sh00010000, 32'sd0, 1'b0, 32'sd0, 1'b0});
    stim_rows.push_back('{1'b0, 2'd2, MODE_STEP, SampleMax, 32'sd0, 1'b0, 32'sd0, 1'b0});
    stim_rows.push_back('{1'b0, 2'd2, MODE_STEP, SampleMin, 32'sd0, 1'b0, 32'sd0, 1'b0});
    stim_rows.push_back('{1'b0, 2'd2, MODE_STEP, 32'sd0, 32'sd0, 1'b0, 32'sd0, 1'b0});
    stim_rows.push_back('{1'b0, 2'd2, MODE_STEP, 32'sd0, 32'sd0, 1'b0, 32'sd0, 1'b0});
    // mirrored extremes cancel to exactly zero
    stim_rows.push_back('{1'b1, 2'd3, MODE_INIT, SampleMax, SampleMin, 1'b0, 32'sd0, 1'b0});
    stim_rows.push_back('{1'b0, 2'd3, MODE_STEP, 32'sd0, 32'sd0, 1'b1, 32'sd0, 1'b0});
    stim_rows.push_back('{1'b0, 2'd3, MODE_STEP, SampleMax, 32'sd0, 1'b0, 32'sd0, 1'b0});
    stim_rows.push_back('{1'b0, 2'd3, MODE_STEP, SampleMin, 32'sd0, 1'b0, 32'sd0, 1'b0});

    // single reset at the start
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, back to back
    foreach (stim_rows[i]) begin
      row = stim_rows[i];
      if (row.load) begin
        for (k = 0; k < Depth; k++) begin
          fb_next[k] = fb_sets[row.set_id][k];
          ff_next[k] = ff_sets[row.set_id][k];
        end
        load_coefs();
      end
      send_beat(row.mode, row.sample, row.rest, row.fixed, row.want_value, row.want_sat);
    end

    // random part: a fresh coefficient set per phase, bursty sender
    burst_left = 0;
    for (ph = 0; ph < RandPhases; ph++) begin
      style = ph % 3;
      for (k = 0; k < Depth; k++) begin
        fb_next[k] = rand_coef(style);
        ff_next[k] = rand_coef(style);
      end
      load_coefs();
      for (n = 0; n < PhaseItems; n++) begin
        if (burst_left == 0) begin
          // now and then hold off until the pipe is empty
          if ($urandom_range(0, 15) == 0) wait_drained();
          else idle_cycles($urandom_range(1, 8));
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(1, 12);
        end
        burst_left--;
        m = ($urandom_range(0, 7) == 0) ? MODE_INIT : MODE_STEP;
        send_beat(m, rand_sample(), rand_sample(), 1'b0, 32'sd0, 1'b0);
      end
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/dtf_pkg.sv
rtl/core/discrete_transfer_function_filter_top.sv
bench/tb_discrete_transfer_function_filter_top.sv
